FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console character writer
// field widths, codes, reset values and the command passed front to back
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // item field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int CELL_COL_W = 6;
    localparam int CELL_ROW_W = 5;
    localparam int COLOUR_W   = 16;
    localparam int BYTE_W     = 8;

    // configuration register widths and port shape
    localparam int CFG_COLS_W = 7;
    localparam int CFG_ROWS_W = 6;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_BACK = 2'd2;
    localparam logic [1:0] REG_FORE = 2'd3;

    // register reset values
    localparam logic [CFG_COLS_W-1:0] RST_COLS = 7'd64;
    localparam logic [CFG_ROWS_W-1:0] RST_ROWS = 6'd32;
    localparam logic [BYTE_W-1:0]     RST_BACK = 8'd0;
    localparam logic [BYTE_W-1:0]     RST_FORE = 8'd15;
    localparam logic [COLOUR_W-1:0]   RST_COLOUR_WORD = {RST_BACK, RST_FORE};

    // op codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // control bytes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam int                TAB_STEP     = 8;

    // default geometry and queue size
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 32;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    // one classified item on its way to the store sequencer
    typedef struct packed {
        cmd_kind_t               kind;
        logic                    cell_write;
        logic                    scroll;
        logic                    read_hit;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_COL_W-1:0]   cursor_col;
        logic [CELL_ROW_W-1:0]   cursor_row;
    } cmd_t;

    // column arithmetic width: holds max columns plus a tab step, at least a register
    function automatic int col_calc_w(input int max_cols);
        int w;
        w = $clog2(max_cols + TAB_STEP);
        return (w > CFG_COLS_W) ? w : CFG_COLS_W;
    endfunction

    // row arithmetic width: holds max rows, at least a register
    function automatic int row_calc_w(input int max_rows);
        int w;
        w = $clog2(max_rows + 1);
        return (w > CFG_ROWS_W) ? w : CFG_ROWS_W;
    endfunction

    function automatic int addr_w(input int cells);
        return (cells > 1) ? $clog2(cells) : 1;
    endfunction

    function automatic int cell_index(input int row, input int col, input int max_cols);
        return row * max_cols + col;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcw_in_if.sv
// ----------------------------------------------------------------------------
// tcw_in_if: input item channel
// valid/ready handshake carrying one console op
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::OP_W-1:0]          op;
    logic [tcw_pkg::CHAR_W-1:0]        char_code;
    logic [tcw_pkg::CELL_COL_W-1:0]    cell_col;
    logic [tcw_pkg::CELL_ROW_W-1:0]    cell_row;

    modport source (output valid, op, char_code, cell_col, cell_row, input ready);
    modport sink   (input valid, op, char_code, cell_col, cell_row, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_out_if.sv
// ----------------------------------------------------------------------------
// tcw_out_if: result item channel
// valid/ready handshake carrying read data and cursor state
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_out_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CHAR_W-1:0]        read_char;
    logic [tcw_pkg::COLOUR_W-1:0]      read_colour;
    logic [tcw_pkg::CELL_COL_W-1:0]    cursor_col_now;
    logic [tcw_pkg::CELL_ROW_W-1:0]    cursor_row_now;
    logic                              did_scroll;

    modport source (output valid, read_char, read_colour, cursor_col_now, cursor_row_now,
                    did_scroll, input ready);
    modport sink   (input valid, read_char, read_colour, cursor_col_now, cursor_row_now,
                    did_scroll, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [tcw_pkg::addr_w(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [tcw_pkg::addr_w(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: small command queue
// register based fifo between the classifier and the store sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] data_out,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: item classifier and cursor tracker
// decodes each op, moves the cursor and queues a store command
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    tcw_in_if.sink                                                  in_ch,
    input  wire logic                                               enable,
    input  wire logic [tcw_pkg::col_calc_w(MAX_COLS)-1:0]           eff_cols,
    input  wire logic [tcw_pkg::row_calc_w(MAX_ROWS)-1:0]           eff_rows,
    input  wire logic                                               q_full,
    output logic                                                    q_push,
    output tcw_pkg::cmd_t                                           q_cmd,
    output logic      [tcw_pkg::addr_w(MAX_COLS*MAX_ROWS)-1:0]      q_addr
);

    localparam int CXW = tcw_pkg::col_calc_w(MAX_COLS);
    localparam int RXW = tcw_pkg::row_calc_w(MAX_ROWS);
    localparam int AW  = tcw_pkg::addr_w(MAX_COLS * MAX_ROWS);
    localparam logic [CXW-1:0] TAB_MASK = CXW'(tcw_pkg::TAB_STEP - 1);

    logic [CXW-1:0] cursor_col_reg, cursor_col_next;
    logic [RXW-1:0] cursor_row_reg, cursor_row_next;

    logic [CXW-1:0] col_sat, col_a, col_b, col_c;
    logic [RXW-1:0] row_sat, row_a, row_b, row_c;
    logic           printable, put_scroll, read_hit;
    logic [CXW-1:0] rd_col;
    logic [RXW-1:0] rd_row;

    assign in_ch.ready = enable && !q_full;
    assign q_push      = in_ch.valid && in_ch.ready;

    // put path: saturate, apply the byte, wrap, then scroll
    always_comb
    begin
        col_sat   = (cursor_col_reg >= eff_cols) ? eff_cols - 1'b1 : cursor_col_reg;
        row_sat   = (cursor_row_reg >= eff_rows) ? eff_rows - 1'b1 : cursor_row_reg;
        printable = 1'b0;
        col_a     = col_sat;
        row_a     = row_sat;
        case (in_ch.char_code)
            tcw_pkg::CH_NEWLINE:
            begin
                col_a = '0;
                row_a = row_sat + 1'b1;
            end
            tcw_pkg::CH_RETURN:
            begin
                col_a = '0;
            end
            tcw_pkg::CH_BACKSPACE:
            begin
                col_a = (col_sat == '0) ? '0 : col_sat - 1'b1;
            end
            tcw_pkg::CH_TAB:
            begin
                col_a = (col_sat & ~TAB_MASK) + CXW'(tcw_pkg::TAB_STEP);
            end
            default:
            begin
                printable = 1'b1;
                col_a     = col_sat + 1'b1;
            end
        endcase

        col_b = col_a;
        row_b = row_a;
        if (col_a >= eff_cols)
        begin
            col_b = '0;
            row_b = row_a + 1'b1;
        end

        put_scroll = (row_b >= eff_rows);
        col_c      = put_scroll ? '0 : col_b;
        row_c      = put_scroll ? eff_rows - 1'b1 : row_b;
    end

    assign rd_col   = CXW'(in_ch.cell_col);
    assign rd_row   = RXW'(in_ch.cell_row);
    assign read_hit = (rd_col < eff_cols) && (rd_row < eff_rows);

    always_comb
    begin
        cursor_col_next    = cursor_col_reg;
        cursor_row_next    = cursor_row_reg;
        q_cmd.kind         = tcw_pkg::CMD_NOP;
        q_cmd.cell_write   = 1'b0;
        q_cmd.scroll       = 1'b0;
        q_cmd.read_hit     = 1'b0;
        q_cmd.char_code    = in_ch.char_code;
        q_addr             = '0;
        unique case (in_ch.op)
            tcw_pkg::OP_PUT:
            begin
                q_cmd.kind       = tcw_pkg::CMD_PUT;
                q_cmd.cell_write = printable;
                q_cmd.scroll     = put_scroll;
                q_addr           = AW'(tcw_pkg::cell_index(int'(row_sat), int'(col_sat),
                                                           MAX_COLS));
                cursor_col_next  = col_c;
                cursor_row_next  = row_c;
            end
            tcw_pkg::OP_READ:
            begin
                q_cmd.kind     = tcw_pkg::CMD_READ;
                q_cmd.read_hit = read_hit;
                q_addr         = AW'(tcw_pkg::cell_index(int'(rd_row), int'(rd_col),
                                                         MAX_COLS));
            end
            tcw_pkg::OP_CLEAR:
            begin
                q_cmd.kind      = tcw_pkg::CMD_CLEAR;
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            tcw_pkg::OP_NOP:
            begin
                q_cmd.kind = tcw_pkg::CMD_NOP;
            end
            default:
            begin
                q_cmd.kind = tcw_pkg::CMD_NOP;
            end
        endcase
        q_cmd.cursor_col = tcw_pkg::CELL_COL_W'(cursor_col_next);
        q_cmd.cursor_row = tcw_pkg::CELL_ROW_W'(cursor_row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (q_push)
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: cell store sequencer
// owns the cell ram: writes, reads, scroll copy, clear and reset sweeps
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               q_empty,
    input  wire tcw_pkg::cmd_t                                      q_cmd,
    input  wire logic [tcw_pkg::addr_w(MAX_COLS*MAX_ROWS)-1:0]      q_addr,
    output logic                                                    q_pop,
    input  wire logic [tcw_pkg::col_calc_w(MAX_COLS)-1:0]           eff_cols,
    input  wire logic [tcw_pkg::row_calc_w(MAX_ROWS)-1:0]           eff_rows,
    input  wire logic [tcw_pkg::COLOUR_W-1:0]                       colour_word,
    output logic                                                    init_busy,
    tcw_out_if.source                                               out_ch
);

    localparam int CXW    = tcw_pkg::col_calc_w(MAX_COLS);
    localparam int RXW    = tcw_pkg::row_calc_w(MAX_ROWS);
    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int AW     = tcw_pkg::addr_w(CELLS);
    localparam int DATA_W = tcw_pkg::CHAR_W + tcw_pkg::COLOUR_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_DRAIN,
        S_BOTTOM,
        S_CLEAR
    } state_t;

    state_t         state_reg;
    tcw_pkg::cmd_t  cmd_reg;
    logic [AW-1:0]  addr_reg;
    logic [AW-1:0]  sweep_reg;
    logic [RXW-1:0] scr_row_reg;
    logic [CXW-1:0] scr_col_reg;
    logic           pend_valid_reg;
    logic [AW-1:0]  pend_addr_reg;
    logic           out_valid_reg;
    logic [tcw_pkg::CHAR_W-1:0]     out_char_reg;
    logic [tcw_pkg::COLOUR_W-1:0]   out_colour_reg;
    logic [tcw_pkg::CELL_COL_W-1:0] out_col_reg;
    logic [tcw_pkg::CELL_ROW_W-1:0] out_row_reg;
    logic                           out_scroll_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [AW-1:0]  scr_dst_addr, scr_src_addr, bottom_addr;
    logic           sweep_last, scr_col_last, scroll_last;
    logic           out_take;

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scr_dst_addr = AW'(tcw_pkg::cell_index(int'(scr_row_reg), int'(scr_col_reg),
                                                  MAX_COLS));
    assign scr_src_addr = AW'(tcw_pkg::cell_index(int'(scr_row_reg) + 1, int'(scr_col_reg),
                                                  MAX_COLS));
    assign bottom_addr  = AW'(tcw_pkg::cell_index(int'(eff_rows) - 1, int'(scr_col_reg),
                                                  MAX_COLS));
    assign sweep_last   = (sweep_reg == AW'(CELLS - 1));
    assign scr_col_last = (scr_col_reg == eff_cols - 1'b1);
    assign scroll_last  = scr_col_last && (scr_row_reg == eff_rows - RXW'(2));

    assign out_take   = out_valid_reg && out_ch.ready;
    assign q_pop      = (state_reg == S_IDLE) && !q_empty && (!out_valid_reg || out_ch.ready);
    assign init_busy  = (state_reg == S_INIT);

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.read_char      = out_char_reg;
    assign out_ch.read_colour    = out_colour_reg;
    assign out_ch.cursor_col_now = out_col_reg;
    assign out_ch.cursor_row_now = out_row_reg;
    assign out_ch.did_scroll     = out_scroll_reg;

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = addr_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = {tcw_pkg::CHAR_W'(0), tcw_pkg::RST_COLOUR_WORD};
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = {tcw_pkg::CHAR_W'(0), colour_word};
            end
            S_EXEC:
            begin
                ram_we    = (cmd_reg.kind == tcw_pkg::CMD_PUT) && cmd_reg.cell_write;
                ram_waddr = addr_reg;
                ram_wdata = {cmd_reg.char_code, colour_word};
            end
            S_SCROLL:
            begin
                ram_raddr = scr_src_addr;
                ram_we    = pend_valid_reg;
            end
            S_DRAIN:
            begin
                ram_we = pend_valid_reg;
            end
            S_BOTTOM:
            begin
                ram_we    = 1'b1;
                ram_waddr = bottom_addr;
                ram_wdata = {tcw_pkg::CHAR_W'(0), colour_word};
            end
            S_IDLE, S_RDWAIT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg   <= q_cmd;
                        addr_reg  <= q_addr;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    pend_valid_reg <= 1'b0;
                    scr_row_reg    <= '0;
                    scr_col_reg    <= '0;
                    sweep_reg      <= '0;
                    if ((cmd_reg.kind == tcw_pkg::CMD_READ) && cmd_reg.read_hit)
                    begin
                        state_reg <= S_RDWAIT;
                    end
                    else if (cmd_reg.kind == tcw_pkg::CMD_CLEAR)
                    begin
                        state_reg <= S_CLEAR;
                    end
                    else if ((cmd_reg.kind == tcw_pkg::CMD_PUT) && cmd_reg.scroll)
                    begin
                        state_reg <= (eff_rows > RXW'(1)) ? S_SCROLL : S_BOTTOM;
                    end
                    else
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= '0;
                        out_colour_reg <= '0;
                        out_col_reg    <= cmd_reg.cursor_col;
                        out_row_reg    <= cmd_reg.cursor_row;
                        out_scroll_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_RDWAIT:
                begin
                    out_valid_reg  <= 1'b1;
                    {out_char_reg, out_colour_reg} <= ram_rdata;
                    out_col_reg    <= cmd_reg.cursor_col;
                    out_row_reg    <= cmd_reg.cursor_row;
                    out_scroll_reg <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                S_SCROLL:
                begin
                    // read one row below, write it back in the following cycle
                    pend_valid_reg <= 1'b1;
                    pend_addr_reg  <= scr_dst_addr;
                    if (scroll_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (scr_col_last)
                    begin
                        scr_col_reg <= '0;
                        scr_row_reg <= scr_row_reg + 1'b1;
                    end
                    else
                    begin
                        scr_col_reg <= scr_col_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    pend_valid_reg <= 1'b0;
                    scr_col_reg    <= '0;
                    state_reg      <= S_BOTTOM;
                end
                S_BOTTOM:
                begin
                    scr_col_reg <= scr_col_reg + 1'b1;
                    if (scr_col_last)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= '0;
                        out_colour_reg <= '0;
                        out_col_reg    <= cmd_reg.cursor_col;
                        out_row_reg    <= cmd_reg.cursor_row;
                        out_scroll_reg <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= '0;
                        out_colour_reg <= '0;
                        out_col_reg    <= cmd_reg.cursor_col;
                        out_row_reg    <= cmd_reg.cursor_row;
                        out_scroll_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a registered read always follows its address cycle
    a_rdwait_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDWAIT) |-> $past(state_reg == S_EXEC))
        else $error("read wait without address cycle");

    // the drain cycle always has a copy write left to do
    a_drain_has_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> pend_valid_reg)
        else $error("drain without pending copy");

    // scroll copy never reads past the last row in use
    a_scroll_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> ((scr_row_reg + RXW'(1)) < eff_rows))
        else $error("scroll source row outside area");

    // a result only appears when the sequencer has returned to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg == S_IDLE))
        else $error("result raised outside idle");

endmodule

`default_nettype wire

FILE: rtl/core/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: character cell store of a text console
// put, read and clear items on a cell ram with cursor, wrap and scroll
// a result item follows every accepted item once the sequencer is done with it;
//   a read inside the area waits for the ram read, a clear sweeps every cell,
//   a scroll copies the area up one row and blanks its bottom row (only the
//   blank with a single row in use)
// items: the sequencer takes one item at a time from the command queue
// reset: a sweep over all MAX_COLS*MAX_ROWS cells blanks the cell ram, no item taken
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tcw_in_if.sink                              in_ch,
    tcw_out_if.source                           out_ch,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]    pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int CXW   = tcw_pkg::col_calc_w(MAX_COLS);
    localparam int RXW   = tcw_pkg::row_calc_w(MAX_ROWS);
    localparam int AW    = tcw_pkg::addr_w(MAX_COLS * MAX_ROWS);
    localparam int CMD_W = $bits(tcw_pkg::cmd_t);
    localparam int Q_W   = CMD_W + AW;

    // configuration registers
    logic [tcw_pkg::CFG_COLS_W-1:0] cols_reg;
    logic [tcw_pkg::CFG_ROWS_W-1:0] rows_reg;
    logic [tcw_pkg::BYTE_W-1:0]     back_reg;
    logic [tcw_pkg::BYTE_W-1:0]     fore_reg;
    logic                           cfg_write;
    logic [1:0]                     reg_index;

    // area in use after clamping to 1..max
    logic [CXW-1:0] cols_wide, eff_cols;
    logic [RXW-1:0] rows_wide, eff_rows;
    logic [tcw_pkg::COLOUR_W-1:0] colour_word;

    // front to queue to back
    logic           push, pop, q_full, q_empty, init_busy;
    tcw_pkg::cmd_t  push_cmd, pop_cmd;
    logic [AW-1:0]  push_addr, pop_addr;
    logic [Q_W-1:0] q_din, q_dout;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= tcw_pkg::RST_COLS;
            rows_reg <= tcw_pkg::RST_ROWS;
            back_reg <= tcw_pkg::RST_BACK;
            fore_reg <= tcw_pkg::RST_FORE;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                tcw_pkg::REG_COLS: cols_reg <= pwdata[tcw_pkg::CFG_COLS_W-1:0];
                tcw_pkg::REG_ROWS: rows_reg <= pwdata[tcw_pkg::CFG_ROWS_W-1:0];
                tcw_pkg::REG_BACK: back_reg <= pwdata[tcw_pkg::BYTE_W-1:0];
                tcw_pkg::REG_FORE: fore_reg <= pwdata[tcw_pkg::BYTE_W-1:0];
                default:           cols_reg <= cols_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_index)
            tcw_pkg::REG_COLS: prdata = tcw_pkg::PDATA_W'(cols_reg);
            tcw_pkg::REG_ROWS: prdata = tcw_pkg::PDATA_W'(rows_reg);
            tcw_pkg::REG_BACK: prdata = tcw_pkg::PDATA_W'(back_reg);
            tcw_pkg::REG_FORE: prdata = tcw_pkg::PDATA_W'(fore_reg);
            default:           prdata = '0;
        endcase
    end

    // zero acts as one, anything past the maximum acts as the maximum
    assign cols_wide = CXW'(cols_reg);
    assign rows_wide = RXW'(rows_reg);
    assign eff_cols  = (cols_wide == '0) ? CXW'(1) :
                       (cols_wide > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : cols_wide;
    assign eff_rows  = (rows_wide == '0) ? RXW'(1) :
                       (rows_wide > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : rows_wide;
    assign colour_word = {back_reg, fore_reg};

    // classifier: takes items, tracks the cursor, emits one command per item
    tcw_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .enable   (!init_busy),
        .eff_cols (eff_cols),
        .eff_rows (eff_rows),
        .q_full   (q_full),
        .q_push   (push),
        .q_cmd    (push_cmd),
        .q_addr   (push_addr)
    );

    // short command queue so the input side keeps taking items during a long scroll or clear until it fills
    assign q_din    = {push_cmd, push_addr};
    assign pop_cmd  = tcw_pkg::cmd_t'(q_dout[Q_W-1:AW]);
    assign pop_addr = q_dout[AW-1:0];

    tcw_queue #(
        .WIDTH (Q_W),
        .DEPTH (tcw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (q_din),
        .full     (q_full),
        .pop      (pop),
        .data_out (q_dout),
        .empty    (q_empty)
    );

    // sequencer: owns the cell ram and the result register
    tcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_addr      (pop_addr),
        .q_pop       (pop),
        .eff_cols    (eff_cols),
        .eff_rows    (eff_rows),
        .colour_word (colour_word),
        .init_busy   (init_busy),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

FILE: dv/tcw_console_checker.sv
// ----------------------------------------------------------------------------
// tcw_console_checker: result checker of the text console character writer
// watches the item channels and the register port, keeps its own copy of the
// cell store, cursor and registers, and compares every result item in order
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_console_checker
    import tcw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    tcw_in_if                       in_ch,
    tcw_out_if                      out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output int                      fail_count,
    output int                      results_waiting
);

    localparam int COLS_MAX   = DEF_MAX_COLS;
    localparam int ROWS_MAX   = DEF_MAX_ROWS;
    localparam int CELL_COUNT = COLS_MAX * ROWS_MAX;

    typedef struct packed {
        logic [CHAR_W-1:0]     read_char;
        logic [COLOUR_W-1:0]   read_colour;
        logic [CELL_COL_W-1:0] cursor_col;
        logic [CELL_ROW_W-1:0] cursor_row;
        logic                  did_scroll;
    } console_result_t;

    logic [CFG_COLS_W-1:0] cols_reg;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [BYTE_W-1:0]     back_reg;
    logic [BYTE_W-1:0]     fore_reg;
    logic [CELL_COL_W-1:0] cur_col;
    logic [CELL_ROW_W-1:0] cur_row;
    logic [CHAR_W-1:0]     char_cells [CELL_COUNT];
    logic [COLOUR_W-1:0]   colour_cells [CELL_COUNT];
    console_result_t       expected_q [$];

    task automatic fill_store(input logic [COLOUR_W-1:0] colour);
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            char_cells[i]   = '0;
            colour_cells[i] = colour;
        end
    endtask

    // move the area in use up one row, blank its bottom row, cursor up a row (not past the top) to column zero
    task automatic scroll_area(input int cols, input int rows, inout int row, inout int col);
        int dst;
        for (int r = 0; r + 1 < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                dst = r * COLS_MAX + c;
                char_cells[dst]   = char_cells[dst + COLS_MAX];
                colour_cells[dst] = colour_cells[dst + COLS_MAX];
            end
        end
        for (int c = 0; c < cols; c++)
        begin
            dst = (rows - 1) * COLS_MAX + c;
            char_cells[dst]   = '0;
            colour_cells[dst] = {back_reg, fore_reg};
        end
        if (row > 0)
            row--;
        col = 0;
    endtask

    task automatic console_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [CELL_COL_W-1:0] rc,
                                input logic [CELL_ROW_W-1:0] rr,
                                output console_result_t res);
        int cols;
        int rows;
        int col;
        int row;
        int idx;
        res  = '0;
        cols = (cols_reg == 0) ? 1 : (cols_reg > COLS_MAX) ? COLS_MAX : int'(cols_reg);
        rows = (rows_reg == 0) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg);
        col  = int'(cur_col);
        row  = int'(cur_row);
        case (op)
            OP_PUT:
            begin
                // cursor left outside a shrunk area saturates first
                if (row >= rows)
                    row = rows - 1;
                if (col >= cols)
                    col = cols - 1;
                if (ch == CH_NEWLINE)
                begin
                    col = 0;
                    row++;
                    if (row >= rows)
                    begin
                        scroll_area(cols, rows, row, col);
                        res.did_scroll = 1'b1;
                    end
                end
                else if (ch == CH_RETURN)
                    col = 0;
                else if (ch == CH_BACKSPACE)
                begin
                    if (col > 0)
                        col--;
                end
                else if (ch == CH_TAB)
                    col += TAB_STEP - (col % TAB_STEP);
                else
                begin
                    idx = row * COLS_MAX + col;
                    char_cells[idx]   = ch;
                    colour_cells[idx] = {back_reg, fore_reg};
                    col++;
                end
                if (col >= cols)
                begin
                    col = 0;
                    row++;
                end
                if (row >= rows)
                begin
                    scroll_area(cols, rows, row, col);
                    res.did_scroll = 1'b1;
                end
            end
            OP_READ:
            begin
                if (rc < cols && rr < rows)
                begin
                    idx = int'(rr) * COLS_MAX + int'(rc);
                    res.read_char   = char_cells[idx];
                    res.read_colour = colour_cells[idx];
                end
            end
            OP_CLEAR:
            begin
                fill_store({back_reg, fore_reg});
                col = 0;
                row = 0;
            end
            default: ;
        endcase
        cur_col        = CELL_COL_W'(col);
        cur_row        = CELL_ROW_W'(row);
        res.cursor_col = cur_col;
        res.cursor_row = cur_row;
    endtask

    function automatic int check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        console_result_t got;
        if (!rst_n)
        begin
            cols_reg = RST_COLS;
            rows_reg = RST_ROWS;
            back_reg = RST_BACK;
            fore_reg = RST_FORE;
            cur_col  = '0;
            cur_row  = '0;
            fill_store(RST_COLOUR_WORD);
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_COLS: cols_reg = pwdata[CFG_COLS_W-1:0];
                    REG_ROWS: rows_reg = pwdata[CFG_ROWS_W-1:0];
                    REG_BACK: back_reg = pwdata[BYTE_W-1:0];
                    REG_FORE: fore_reg = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            // results first: an item accepted now cannot answer in this cycle
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = {out_ch.read_char, out_ch.read_colour, out_ch.cursor_col_now,
                       out_ch.cursor_row_now, out_ch.did_scroll};
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    fail_count += check_field("read_char", want.read_char, got.read_char)
                        + check_field("read_colour", want.read_colour, got.read_colour)
                        + check_field("cursor_col_now", want.cursor_col, got.cursor_col)
                        + check_field("cursor_row_now", want.cursor_row, got.cursor_row)
                        + check_field("did_scroll", want.did_scroll, got.did_scroll);
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                console_step(in_ch.op, in_ch.char_code, in_ch.cell_col, in_ch.cell_row, want);
                expected_q.push_back(want);
            end
        end
        results_waiting = expected_q.size();
    end

endmodule

`default_nettype wire

FILE: dv/text_console_char_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_tb: testbench top of the text console writer
// drives put, read, clear and no-op items plus register writes, with random
// gaps on both channels; a checker beside the block predicts each result
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_tb;
    import tcw_pkg::*;

    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int RANDOM_ITEMS = 2000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int results_waiting;

    // no idling on either side while set
    bit calm;
    // area in use after the last register writes, as the block sees it
    int area_cols;
    int area_rows;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    text_console_char_writer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tcw_console_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .results_waiting (results_waiting)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // colour byte: the two extremes often, else anything
    function automatic logic [BYTE_W-1:0] pick_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return '1;
        return BYTE_W'($urandom());
    endfunction

    // result side: ready drops for random stretches
    initial
    begin
        int stall;
        stall        = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // one item on the input channel; entered and left at a falling edge,
    // valid stays high on exit so back-to-back items need no toggle
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [CELL_COL_W-1:0] col,
                             input logic [CELL_ROW_W-1:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.char_code <= ch;
        in_ch.cell_col  <= col;
        in_ch.cell_row  <= row;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // put with junk in the cell fields, which a put ignores
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, CELL_COL_W'($urandom()), CELL_ROW_W'($urandom()));
    endtask

    task automatic read_cell(input int col, input int row);
        send_item(OP_READ, CHAR_W'($urandom()), CELL_COL_W'(col), CELL_ROW_W'(row));
    endtask

    // stop sending, wait for every expected result, then let the block settle
    task automatic drain_block(input int settle);
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (results_waiting != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // register write: setup then access, then back to idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [PDATA_W-1:0] data;
        data = PDATA_W'(value);
        // unused upper data bits now and then carry junk
        if ($urandom_range(0, 3) == 0)
            data[PDATA_W-1:8] = (PDATA_W - 8)'($urandom());
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // new console geometry and colours, written only with the block idle
    task automatic set_console(input int cols, input int rows,
                               input logic [7:0] back, input logic [7:0] fore);
        drain_block(8);
        write_reg(REG_COLS, 8'(cols));
        write_reg(REG_ROWS, 8'(rows));
        write_reg(REG_BACK, back);
        write_reg(REG_FORE, fore);
        area_cols = (cols == 0) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
        area_rows = (rows == 0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
    endtask

    // random item shaped like console text: mostly puts, some reads,
    // rare clears and no-ops
    task automatic random_item();
        int r;
        logic [CHAR_W-1:0] ch;
        r = $urandom_range(0, 999);
        if (r < 5)
            send_item(OP_CLEAR, CHAR_W'($urandom()), CELL_COL_W'($urandom()),
                      CELL_ROW_W'($urandom()));
        else if (r < 25)
            send_item(OP_NOP, CHAR_W'($urandom()), CELL_COL_W'($urandom()),
                      CELL_ROW_W'($urandom()));
        else if (r < 250)
        begin
            // mostly inside the area, the rest anywhere in the field range
            if ($urandom_range(0, 4) != 0)
                read_cell($urandom_range(0, area_cols - 1), $urandom_range(0, area_rows - 1));
            else
                read_cell($urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                ch = CH_NEWLINE;
            else if (r < 15)
                ch = CH_RETURN;
            else if (r < 20)
                ch = CH_BACKSPACE;
            else if (r < 26)
                ch = CH_TAB;
            else
                ch = CHAR_W'($urandom());
            put_char(ch);
        end
    endtask

    initial
    begin
        int sent;
        int kind;
        int n;
        int cols;
        int rows;

        // every input known from time zero
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_NOP;
        in_ch.char_code = '0;
        in_ch.cell_col  = '0;
        in_ch.cell_row  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        calm            = 1'b0;
        area_cols       = MAX_COLS;
        area_rows       = MAX_ROWS;
        sent            = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset geometry; the block blanks its store first, the
        // first handshake simply waits for that
        read_cell(0, 0);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CH_TAB);
        put_char(CH_BACKSPACE);
        put_char(CH_RETURN);
        put_char(CH_NEWLINE);
        // no-op with every field bit set
        send_item(OP_NOP, '1, '1, '1);
        read_cell(0, 0);
        read_cell(MAX_COLS - 1, MAX_ROWS - 1);
        send_item(OP_CLEAR, '0, '0, '0);
        read_cell(1, 0);

        // tiny area: wrap, then newline on the last row scrolls
        set_console(3, 2, 8'hAA, 8'h55);
        put_char(8'h61);
        put_char(8'h62);
        put_char(8'h63);
        put_char(8'h64);
        put_char(CH_NEWLINE);
        read_cell(0, 0);
        // outside the area reads as zero
        read_cell(5, 0);

        // zero registers act as one; cursor left on row 1 saturates
        set_console(0, 0, 8'h00, 8'hFF);
        put_char(8'h71);
        put_char(CH_TAB);
        put_char(CH_BACKSPACE);

        // registers above the maximum act as the maximum
        set_console(127, 63, 8'hFF, 8'h00);
        put_char(8'h7E);
        read_cell(MAX_COLS - 1, MAX_ROWS - 1);

        // random phases, each with its own geometry and colours; large
        // areas make every scroll slow, so they get few items
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(50, 110);
            case (kind)
                0:
                begin
                    cols = $urandom_range(MAX_COLS, 127);
                    rows = $urandom_range(MAX_ROWS, 63);
                    n    = 40;
                end
                1:
                begin
                    cols = $urandom_range(0, 1);
                    rows = $urandom_range(0, 1);
                    n    = $urandom_range(30, 60);
                end
                2:
                begin
                    cols = MAX_COLS;
                    rows = $urandom_range(1, 3);
                end
                3:
                begin
                    cols = $urandom_range(1, 4);
                    rows = MAX_ROWS;
                end
                default:
                begin
                    cols = $urandom_range(1, 16);
                    rows = $urandom_range(1, 8);
                end
            endcase
            set_console(cols, rows, pick_colour(), pick_colour());
            // some phases run with no idling at all
            calm = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < n; i++)
                random_item();
            sent += n;
        end

        calm = 1'b0;
        drain_block(20);
        if (fail_count == 0)
            $display("PASS text_console_char_writer");
        else
            $display("FAIL text_console_char_writer");
        $finish;
    end

    // run limit, far beyond the slowest correct run (every item a full
    // area scroll or clear under the longest gaps)
    initial
    begin
        #1000000000;
        $display("FAIL text_console_char_writer");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_in_if.sv
rtl/core/tcw_out_if.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_char_writer.sv
dv/tcw_console_checker.sv
dv/text_console_char_writer_tb.sv
